[src/pixel_format_convert_blend_top_defines.svh]
// Assertion macros shared by the pixel format converter RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef PIXEL_FORMAT_CONVERT_BLEND_TOP_DEFINES_SVH
`define PIXEL_FORMAT_CONVERT_BLEND_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define PFCB_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Implication check failed");

// Whenever the antecedent holds, the consequent holds a fixed number of cycles later.
`define PFCB_ASSERT_LAT(name, clk, rst_n, ante, n, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("Latency check failed");

`else

`define PFCB_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define PFCB_ASSERT_LAT(name, clk, rst_n, ante, n, cons)

`endif

`endif

[src/pfcb_pkg.sv]
`default_nettype none

package pfcb_pkg;

	// Channel and arithmetic widths.
	localparam int CH_W  = 8;
	localparam int SUM_W = 10;
	localparam int NUM_W = 18;
	localparam int DEN_W = 10;
	localparam int NUM_LANES = 3;

	// One quotient bit is resolved per divider stage.
	localparam int DIV_STAGES = 8;

	// Constants of the transforms and the packers.
	localparam logic [DEN_W-1:0] BRIGHT_DIV    = 10'd765;
	localparam logic [SUM_W-1:0] AVG_RECIP     = 10'd683;
	localparam int               AVG_SHIFT     = 11;
	localparam logic [CH_W-1:0]  NIB_THRESH    = 8'h60;
	localparam logic [CH_W-1:0]  INTENS_THRESH = 8'h80;
	localparam logic [CH_W-1:0]  SPACE_CHAR    = 8'h20;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_SOURCE_FORMAT   = 2'd0,
		CFG_TARGET_FORMAT   = 2'd1,
		CFG_TRANSFORM_MODE  = 2'd2,
		CFG_TRANSFORM_COLOR = 2'd3
	} cfg_index_t;

	// Byte orders, used for both source and target.
	typedef enum logic [2:0] {
		SF_RGBA = 3'd0,
		SF_RBGA = 3'd1,
		SF_BRGA = 3'd2,
		SF_BGRA = 3'd3,
		SF_GBRA = 3'd4,
		SF_GRBA = 3'd5
	} src_fmt_t;

	// Target formats; the all-ones code is invalid.
	typedef enum logic [3:0] {
		TF_RGBA     = 4'd0,
		TF_RBGA     = 4'd1,
		TF_BRGA     = 4'd2,
		TF_BGRA     = 4'd3,
		TF_GBRA     = 4'd4,
		TF_GRBA     = 4'd5,
		TF_MONO8    = 4'd6,
		TF_MONO16   = 4'd7,
		TF_MONO32   = 4'd8,
		TF_MONO64   = 4'd9,
		TF_VGA_CHAR = 4'd10,
		TF_ASCII    = 4'd11,
		TF_R1G1B1I1 = 4'd12,
		TF_R3G3B2   = 4'd13,
		TF_VGA_ATTR = 4'd14
	} tgt_fmt_t;

	// Transform modes; the unused code behaves as no transform.
	typedef enum logic [1:0] {
		TM_NONE   = 2'd0,
		TM_TINT   = 2'd1,
		TM_BRIGHT = 2'd2
	} xform_mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_SRC = 2'd1,
		ST_BAD_TGT = 2'd2
	} status_t;

	// Control that travels alongside each pixel through the pipeline.
	typedef struct packed {
		logic            valid;
		logic            src_bad;
		logic [CH_W-1:0] alpha;
	} pipe_ctrl_t;

	// Byte position of channel ch (0 red, 1 green, 2 blue) for a byte order.
	function automatic logic [1:0] order_pos(input logic [2:0] fmt, input int ch);
		logic [5:0] pos_set;
		begin
			// Positions packed as {blue, green, red}.
			case (fmt)
				SF_RGBA: pos_set = {2'd2, 2'd1, 2'd0};
				SF_RBGA: pos_set = {2'd1, 2'd2, 2'd0};
				SF_BRGA: pos_set = {2'd0, 2'd2, 2'd1};
				SF_BGRA: pos_set = {2'd0, 2'd1, 2'd2};
				SF_GBRA: pos_set = {2'd1, 2'd0, 2'd2};
				SF_GRBA: pos_set = {2'd2, 2'd0, 2'd1};
				default: pos_set = '0;
			endcase
			return pos_set[2*ch +: 2];
		end
	endfunction

endpackage

`default_nettype wire

[src/pixel_format_convert_blend_top.sv]
// Channel    | Signals                                    | Direction | Handshake
// -----------+--------------------------------------------+-----------+-------------------------
// pixel      | start, busy, pixel_in                      | in        | start while busy is low
// result     | done, pixel_out, out_bytes, write_enable,  | out       | done strobe, one cycle
//            | status                                     |           |
// config     | cfg_valid, cfg_ready, cfg_index, cfg_data  | in        | valid and ready
//
// One pixel request is taken every clock; busy never rises.
// Each request passes in order through unpack, numerator, eight
// restoring-divider stages (one quotient bit each), channel sum, and pack.
// Reset clears the configuration registers and the stage valid bits.
// The receiver cannot stall, so the pipeline advances on every clock.
`default_nettype none

`include "pixel_format_convert_blend_top_defines.svh"

module pixel_format_convert_blend_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [31:0]          pixel_in,
	output logic                      done,
	output logic [63:0]               pixel_out,
	output logic [3:0]                out_bytes,
	output logic                      write_enable,
	output logic [1:0]                status,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire pfcb_pkg::cfg_index_t cfg_index,
	input  wire logic [31:0]          cfg_data
);

	import pfcb_pkg::*;

	// Cycles from an accepted request to its done strobe.
	localparam int PIPE_DEPTH = DIV_STAGES + 4;

	// Configuration registers.
	logic [2:0]  source_format_q;
	logic [3:0]  target_format_q;
	logic [1:0]  transform_mode_q;
	logic [31:0] transform_color_q;

	// Stage 1: unpacked channels and their sum.
	pipe_ctrl_t      ctrl_s1;
	logic [CH_W-1:0] chan_s1 [NUM_LANES];
	logic [SUM_W-1:0] sum_s1;

	// Divider pipeline; index 0 is loaded by stage 2.
	pipe_ctrl_t       div_ctrl_s [DIV_STAGES+1];
	logic [NUM_W-1:0] div_rem_s  [DIV_STAGES+1][NUM_LANES];
	logic [CH_W-1:0]  div_quo_s  [DIV_STAGES+1][NUM_LANES];
	logic [DEN_W-1:0] div_den_s  [DIV_STAGES+1];

	// Stage after the divider: transformed channels and their sum.
	pipe_ctrl_t       ctrl_s11;
	logic [CH_W-1:0]  chan_s11 [NUM_LANES];
	logic [SUM_W-1:0] sum_s11;

	// Output registers.
	logic        done_q;
	logic [63:0] pixel_out_q;
	logic [3:0]  out_bytes_q;
	logic        write_enable_q;
	logic [1:0]  status_q;

	logic accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q   <= '0;
			target_format_q   <= '0;
			transform_mode_q  <= '0;
			transform_color_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SOURCE_FORMAT:   source_format_q   <= cfg_data[2:0];
				CFG_TARGET_FORMAT:   target_format_q   <= cfg_data[3:0];
				CFG_TRANSFORM_MODE:  transform_mode_q  <= cfg_data[1:0];
				CFG_TRANSFORM_COLOR: transform_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: pick R, G and B out of the source byte order.
	logic [CH_W-1:0] unp_chan [NUM_LANES];
	logic            unp_bad;

	always_comb begin
		unp_bad = !(source_format_q inside {[SF_RGBA:SF_GRBA]});
		for (int l = 0; l < NUM_LANES; l++) begin
			unp_chan[l] = pixel_in[8*order_pos(source_format_q, l) +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid   <= accept;
			ctrl_s1.src_bad <= unp_bad;
			ctrl_s1.alpha   <= pixel_in[31:24];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_LANES; l++) begin
			chan_s1[l] <= unp_chan[l];
		end
		sum_s1 <= SUM_W'(unp_chan[0]) + SUM_W'(unp_chan[1]) + SUM_W'(unp_chan[2]);
	end

	// Stage 2: form numerator and denominator of each channel's quotient.
	// No transform divides the channel by one.
	logic [CH_W-1:0]  tint_alpha;
	logic [CH_W-1:0]  col_chan [NUM_LANES];
	logic [NUM_W-1:0] num_nx [NUM_LANES];
	logic [DEN_W-1:0] den_nx;

	always_comb begin
		tint_alpha = transform_color_q[31:24];
		for (int l = 0; l < NUM_LANES; l++) begin
			col_chan[l] = transform_color_q[8*l +: 8];
		end
		den_nx = DEN_W'(1);
		for (int l = 0; l < NUM_LANES; l++) begin
			num_nx[l] = NUM_W'(chan_s1[l]);
		end
		if (transform_mode_q == TM_TINT) begin
			if (ctrl_s1.alpha != '0 && tint_alpha != '0) begin
				den_nx = DEN_W'(tint_alpha) + DEN_W'(ctrl_s1.alpha);
				for (int l = 0; l < NUM_LANES; l++) begin
					num_nx[l] = NUM_W'(tint_alpha) * NUM_W'(col_chan[l])
						+ NUM_W'(ctrl_s1.alpha) * NUM_W'(chan_s1[l]);
				end
			end
		end else if (transform_mode_q == TM_BRIGHT) begin
			den_nx = BRIGHT_DIV;
			for (int l = 0; l < NUM_LANES; l++) begin
				num_nx[l] = NUM_W'(col_chan[l]) * NUM_W'(sum_s1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_ctrl_s[0] <= '0;
		end else begin
			div_ctrl_s[0] <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		div_den_s[0] <= den_nx;
		for (int l = 0; l < NUM_LANES; l++) begin
			div_rem_s[0][l] <= num_nx[l];
			div_quo_s[0][l] <= '0;
		end
	end

	// Restoring divider: each stage tries the denominator at one bit weight.
	// Every numerator stays below 256 times its denominator, so eight bits suffice.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		localparam int SH = DIV_STAGES - 1 - k;

		logic [NUM_W:0]   den_sh;
		logic [NUM_W:0]   diff [NUM_LANES];
		logic             fits [NUM_LANES];

		always_comb begin
			den_sh = (NUM_W+1)'(div_den_s[k]) << SH;
			for (int l = 0; l < NUM_LANES; l++) begin
				diff[l] = {1'b0, div_rem_s[k][l]} - den_sh;
				fits[l] = !diff[l][NUM_W];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_ctrl_s[k+1] <= '0;
			end else begin
				div_ctrl_s[k+1] <= div_ctrl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			div_den_s[k+1] <= div_den_s[k];
			for (int l = 0; l < NUM_LANES; l++) begin
				div_rem_s[k+1][l] <= fits[l] ? diff[l][NUM_W-1:0] : div_rem_s[k][l];
				div_quo_s[k+1][l] <= {div_quo_s[k][l][CH_W-2:0], fits[l]};
			end
		end
	end

	// Stage after the divider: quotients are the new channels; sum them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s11 <= '0;
		end else begin
			ctrl_s11 <= div_ctrl_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_LANES; l++) begin
			chan_s11[l] <= div_quo_s[DIV_STAGES][l];
		end
		sum_s11 <= SUM_W'(div_quo_s[DIV_STAGES][0]) + SUM_W'(div_quo_s[DIV_STAGES][1])
			+ SUM_W'(div_quo_s[DIV_STAGES][2]);
	end

	// Pack stage: average by reciprocal multiply, then build the target word.
	logic [2*SUM_W-1:0] avg_prod;
	logic [CH_W-1:0]    avg;
	logic [3:0]         nib;
	logic [63:0]        word_nx;
	logic [3:0]         nbytes_nx;
	logic [1:0]         status_nx;

	always_comb begin
		avg_prod = sum_s11 * AVG_RECIP;
		avg      = avg_prod[AVG_SHIFT +: CH_W];
		nib      = {avg >= INTENS_THRESH, chan_s11[2] >= NIB_THRESH,
			chan_s11[1] >= NIB_THRESH, chan_s11[0] >= NIB_THRESH};
		word_nx   = '0;
		nbytes_nx = 4'd1;
		status_nx = ST_OK;
		if (ctrl_s11.src_bad) begin
			status_nx = ST_BAD_SRC;
		end else begin
			case (target_format_q)
				TF_RGBA, TF_RBGA, TF_BRGA, TF_BGRA, TF_GBRA, TF_GRBA: begin
					word_nx[31:24] = ctrl_s11.alpha;
					for (int l = 0; l < NUM_LANES; l++) begin
						word_nx[8*order_pos(target_format_q[2:0], l) +: 8] = chan_s11[l];
					end
					nbytes_nx = 4'd4;
				end
				TF_MONO8: word_nx[7:0] = avg;
				TF_MONO16: begin
					word_nx[15:8] = avg;
					nbytes_nx     = 4'd2;
				end
				TF_MONO32: begin
					word_nx[31:24] = avg;
					nbytes_nx      = 4'd4;
				end
				TF_MONO64: begin
					word_nx[63:56] = avg;
					nbytes_nx      = 4'd8;
				end
				TF_VGA_CHAR, TF_ASCII: word_nx[7:0] = SPACE_CHAR;
				TF_R1G1B1I1: word_nx[3:0] = nib;
				TF_R3G3B2: word_nx[7:0] = {chan_s11[2][7:6], chan_s11[1][7:5],
					chan_s11[0][7:5]};
				TF_VGA_ATTR: word_nx[7:4] = nib;
				default: status_nx = ST_BAD_TGT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_s11.valid;
		end
	end

	always_ff @(posedge clk) begin
		pixel_out_q    <= word_nx;
		out_bytes_q    <= nbytes_nx;
		status_q       <= status_nx;
		write_enable_q <= (status_nx == ST_OK) && (ctrl_s11.alpha != '0);
	end

	assign done         = done_q;
	assign pixel_out    = pixel_out_q;
	assign out_bytes    = out_bytes_q;
	assign write_enable = write_enable_q;
	assign status       = status_q;

	// Every request yields its result after the fixed pipeline depth.
	`PFCB_ASSERT_LAT(a_latency, clk, arst_n, accept, PIPE_DEPTH, done)
	// Byte counts are one of the four packed widths.
	`PFCB_ASSERT_IMPL(a_nbytes, clk, arst_n, done,
		out_bytes == 4'd1 || out_bytes == 4'd2 || out_bytes == 4'd4 || out_bytes == 4'd8)
	// An error result carries an empty one-byte word and no write.
	`PFCB_ASSERT_IMPL(a_err_word, clk, arst_n, done && status != ST_OK,
		pixel_out == '0 && out_bytes == 4'd1 && !write_enable)
	// The divider never leaves a lane-0 remainder as large as its denominator.
	`PFCB_ASSERT_IMPL(a_div_rem, clk, arst_n, div_ctrl_s[DIV_STAGES].valid,
		div_rem_s[DIV_STAGES][0] < NUM_W'(div_den_s[DIV_STAGES]))

endmodule

`default_nettype wire
